[rtl/lds_pkg.sv]
// shared types and constants for the lfsr dissolve pixel sequencer
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps
`default_nettype none

package lds_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_AREA_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_AREA_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_PIXEL_SCALE  = 3'd2;
    localparam logic [2:0] CFG_ROW_PITCH    = 3'd3;
    localparam logic [2:0] CFG_SOURCE_BASE  = 3'd4;
    localparam logic [2:0] CFG_DEST_BASE    = 3'd5;
    localparam logic [2:0] CFG_ABORT_ENABLE = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int LFSR_W     = 17;
    localparam int ADDR_W     = 23;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 17'd1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 17'h12000;

    // configuration register reset values
    localparam logic [8:0]  RST_AREA_WIDTH  = 9'd319;
    localparam logic [7:0]  RST_AREA_HEIGHT = 8'd199;
    localparam logic [2:0]  RST_PIXEL_SCALE = 3'd1;
    localparam logic [10:0] RST_ROW_PITCH   = 11'd320;

    typedef struct packed {
        logic [8:0]  area_width;
        logic [7:0]  area_height;
        logic [2:0]  pixel_scale;
        logic [10:0] row_pitch;
        logic [21:0] source_base;
        logic [21:0] dest_base;
        logic        abort_enable;
    } t_lds_cfg;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_BASE,
        ST_EMIT
    } t_lds_state;

    // what kind of request is being served
    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_HIDDEN,
        KIND_ABORT,
        KIND_AFTER
    } t_lds_kind;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic mul_row;
        logic mul_base;
        logic emit;
    } t_lds_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } t_lds_status;

endpackage

`default_nettype wire

[rtl/lfsr_dissolve_pixel_sequencer_core.sv]
// top level of the lfsr dissolve pixel sequencer
// depends on lds_pkg, lds_cfg_regs, lds_ctrl and lds_datapath
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_ready    | i_abort_request
//  out     | o_out_valid / i_out_ready  | o_source_addr o_dest_addr o_pixel_x
//          |                            | o_pixel_y o_copy_valid o_last_of_step
//          |                            | o_sequence_done o_aborted
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// a request gives n results (scale*scale for a visible pixel, else 1) after the two registered
// multiplies, one result per cycle from the output register while the output does not stall
// reset (synchronous, active low) loads the lfsr seed and register defaults
// a stalled output holds the block in its emit state; the next request is taken
// once the last result of the current one sits in the output register
`timescale 1ns / 1ps
`default_nettype none

module lfsr_dissolve_pixel_sequencer_core #(
    parameter int MAX_SCALE = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_abort_request,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [lds_pkg::ADDR_W-1:0]          o_source_addr,
    output logic [lds_pkg::ADDR_W-1:0]          o_dest_addr,
    output logic [8:0]                          o_pixel_x,
    output logic [7:0]                          o_pixel_y,
    output logic                                o_copy_valid,
    output logic                                o_last_of_step,
    output logic                                o_sequence_done,
    output logic                                o_aborted,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lds_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lds_pkg::t_lds_cfg    cfg;
    lds_pkg::t_lds_cmd    cmd;
    lds_pkg::t_lds_status status;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    lds_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    lds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    lds_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_abort_request (i_abort_request),
        .o_source_addr   (o_source_addr),
        .o_dest_addr     (o_dest_addr),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_copy_valid    (o_copy_valid),
        .o_last_of_step  (o_last_of_step),
        .o_sequence_done (o_sequence_done),
        .o_aborted       (o_aborted)
    );

endmodule

`default_nettype wire

[rtl/lds_cfg_regs.sv]
// configuration register file of the dissolve sequencer
// depends on lds_pkg for register indexes, reset values and the config struct
`timescale 1ns / 1ps
`default_nettype none

module lds_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [lds_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [lds_pkg::CFG_DATA_W-1:0] i_wr_data,
    output lds_pkg::t_lds_cfg                   o_cfg
);

    lds_pkg::t_lds_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_width   <= lds_pkg::RST_AREA_WIDTH;
            r_cfg.area_height  <= lds_pkg::RST_AREA_HEIGHT;
            r_cfg.pixel_scale  <= lds_pkg::RST_PIXEL_SCALE;
            r_cfg.row_pitch    <= lds_pkg::RST_ROW_PITCH;
            r_cfg.source_base  <= '0;
            r_cfg.dest_base    <= '0;
            r_cfg.abort_enable <= 1'b0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                lds_pkg::CFG_AREA_WIDTH:   r_cfg.area_width   <= i_wr_data[8:0];
                lds_pkg::CFG_AREA_HEIGHT:  r_cfg.area_height  <= i_wr_data[7:0];
                lds_pkg::CFG_PIXEL_SCALE:  r_cfg.pixel_scale  <= i_wr_data[2:0];
                lds_pkg::CFG_ROW_PITCH:    r_cfg.row_pitch    <= i_wr_data[10:0];
                lds_pkg::CFG_SOURCE_BASE:  r_cfg.source_base  <= i_wr_data[21:0];
                lds_pkg::CFG_DEST_BASE:    r_cfg.dest_base    <= i_wr_data[21:0];
                lds_pkg::CFG_ABORT_ENABLE: r_cfg.abort_enable <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/lds_ctrl.sv]
// controller state machine of the dissolve sequencer: handshakes and sequencing
// depends on lds_pkg for the state type and the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module lds_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output lds_pkg::t_lds_cmd          o_cmd,
    input  wire lds_pkg::t_lds_status  i_status
);

    lds_pkg::t_lds_state r_state;
    lds_pkg::t_lds_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                out_free;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lds_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            lds_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = lds_pkg::ST_ROW;
                end
            end
            lds_pkg::ST_ROW: begin
                o_cmd.mul_row = 1'b1;
                n_state       = lds_pkg::ST_BASE;
            end
            lds_pkg::ST_BASE: begin
                o_cmd.mul_base = 1'b1;
                n_state        = lds_pkg::ST_EMIT;
            end
            lds_pkg::ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.last) begin
                        n_state = lds_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = lds_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/lds_datapath.sv]
// datapath of the dissolve sequencer: lfsr, end flags, address arithmetic
// and the output register; depends on lds_pkg
`timescale 1ns / 1ps
`default_nettype none

module lds_datapath #(
    parameter int MAX_SCALE = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lds_pkg::t_lds_cfg             i_cfg,
    input  wire lds_pkg::t_lds_cmd             i_cmd,
    output lds_pkg::t_lds_status               o_status,
    input  wire logic                          i_abort_request,
    output logic [lds_pkg::ADDR_W-1:0]         o_source_addr,
    output logic [lds_pkg::ADDR_W-1:0]         o_dest_addr,
    output logic [8:0]                         o_pixel_x,
    output logic [7:0]                         o_pixel_y,
    output logic                               o_copy_valid,
    output logic                               o_last_of_step,
    output logic                               o_sequence_done,
    output logic                               o_aborted
);

    localparam int AW = lds_pkg::ADDR_W;

    // sequence state
    logic [lds_pkg::LFSR_W-1:0] r_lfsr;
    logic                       r_finished;
    logic                       r_aborted_flag;

    // per request working registers
    lds_pkg::t_lds_kind r_kind;
    logic               r_done;
    logic               r_ab_out;
    logic [8:0]         r_x;
    logic [7:0]         r_y;
    logic [18:0]        r_prod;
    logic [2:0]         r_scale;
    logic [2:0]         r_dx;
    logic [2:0]         r_dy;
    logic [AW-1:0]      r_row_start;
    logic [AW-1:0]      r_off;

    // output register
    logic [AW-1:0] r_src;
    logic [AW-1:0] r_dst;
    logic [8:0]    r_ox;
    logic [7:0]    r_oy;
    logic          r_ovalid;
    logic          r_olast;
    logic          r_odone;
    logic          r_oab;

    logic [lds_pkg::LFSR_W-1:0] n_lfsr;
    logic [8:0]                 cur_x;
    logic [7:0]                 cur_y;
    logic                       visible;
    logic [2:0]                 scale_clamped;
    logic [19:0]                lin_sum;
    logic [AW-1:0]              row_next;
    logic                       dx_end;
    logic                       dy_end;
    logic                       block_last;

    // coordinates from the current lfsr and its next value
    assign cur_x   = r_lfsr[16:8];
    assign cur_y   = r_lfsr[7:0] - 8'd1;
    assign n_lfsr  = {1'b0, r_lfsr[16:1]} ^ (r_lfsr[0] ? lds_pkg::LFSR_TAPS : '0);
    assign visible = (cur_x <= i_cfg.area_width) && (cur_y <= i_cfg.area_height);

    // scale limited to 1..MAX_SCALE
    always_comb begin
        if (i_cfg.pixel_scale == 3'd0) begin
            scale_clamped = 3'd1;
        end else if (32'(i_cfg.pixel_scale) > MAX_SCALE) begin
            scale_clamped = 3'(MAX_SCALE);
        end else begin
            scale_clamped = i_cfg.pixel_scale;
        end
    end

    assign lin_sum    = {1'b0, r_prod} + {11'd0, r_x};
    assign row_next   = r_row_start + {12'd0, i_cfg.row_pitch};
    assign dx_end     = (r_dx == r_scale - 3'd1);
    assign dy_end     = (r_dy == r_scale - 3'd1);
    assign block_last = dx_end && dy_end;

    assign o_status.last = (r_kind != lds_pkg::KIND_PIXEL) || block_last;

    // lfsr and end flags, updated when a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr         <= lds_pkg::LFSR_SEED;
            r_finished     <= 1'b0;
            r_aborted_flag <= 1'b0;
        end else if (i_cmd.start && !r_finished) begin
            if (i_cfg.abort_enable && i_abort_request) begin
                r_finished     <= 1'b1;
                r_aborted_flag <= 1'b1;
            end else begin
                r_lfsr <= n_lfsr;
                if (n_lfsr == lds_pkg::LFSR_SEED) begin
                    r_finished <= 1'b1;
                end
            end
        end
    end

    // request classification and address arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x      <= cur_x;
            r_y      <= cur_y;
            r_done   <= (n_lfsr == lds_pkg::LFSR_SEED);
            r_ab_out <= r_aborted_flag;
            if (r_finished) begin
                r_kind <= lds_pkg::KIND_AFTER;
            end else if (i_cfg.abort_enable && i_abort_request) begin
                r_kind <= lds_pkg::KIND_ABORT;
            end else if (visible) begin
                r_kind <= lds_pkg::KIND_PIXEL;
            end else begin
                r_kind <= lds_pkg::KIND_HIDDEN;
            end
        end
        // first multiply: row index times pitch
        if (i_cmd.mul_row) begin
            r_prod  <= 19'({11'd0, r_y} * {8'd0, i_cfg.row_pitch});
            r_scale <= scale_clamped;
        end
        // second multiply: scaled linear offset of the block corner
        if (i_cmd.mul_base) begin
            r_row_start <= AW'({20'd0, r_scale} * {3'd0, lin_sum});
            r_off       <= AW'({20'd0, r_scale} * {3'd0, lin_sum});
            r_dx        <= 3'd0;
            r_dy        <= 3'd0;
        end
        // walk the block in row order
        if (i_cmd.emit && r_kind == lds_pkg::KIND_PIXEL) begin
            if (dx_end) begin
                r_dx        <= 3'd0;
                r_dy        <= r_dy + 3'd1;
                r_row_start <= row_next;
                r_off       <= row_next;
            end else begin
                r_dx  <= r_dx + 3'd1;
                r_off <= r_off + {{(AW-1){1'b0}}, 1'b1};
            end
        end
    end

    // output register load
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (r_kind)
                lds_pkg::KIND_PIXEL: begin
                    r_src    <= {1'b0, i_cfg.source_base} + r_off;
                    r_dst    <= {1'b0, i_cfg.dest_base} + r_off;
                    r_ox     <= r_x;
                    r_oy     <= r_y;
                    r_ovalid <= 1'b1;
                    r_olast  <= block_last;
                    r_odone  <= block_last && r_done;
                    r_oab    <= 1'b0;
                end
                lds_pkg::KIND_HIDDEN: begin
                    r_src    <= '0;
                    r_dst    <= '0;
                    r_ox     <= r_x;
                    r_oy     <= r_y;
                    r_ovalid <= 1'b0;
                    r_olast  <= 1'b1;
                    r_odone  <= r_done;
                    r_oab    <= 1'b0;
                end
                lds_pkg::KIND_ABORT: begin
                    r_src    <= '0;
                    r_dst    <= '0;
                    r_ox     <= '0;
                    r_oy     <= '0;
                    r_ovalid <= 1'b0;
                    r_olast  <= 1'b1;
                    r_odone  <= 1'b1;
                    r_oab    <= 1'b1;
                end
                default: begin
                    r_src    <= '0;
                    r_dst    <= '0;
                    r_ox     <= '0;
                    r_oy     <= '0;
                    r_ovalid <= 1'b0;
                    r_olast  <= 1'b1;
                    r_odone  <= 1'b1;
                    r_oab    <= r_ab_out;
                end
            endcase
        end
    end

    assign o_source_addr   = r_src;
    assign o_dest_addr     = r_dst;
    assign o_pixel_x       = r_ox;
    assign o_pixel_y       = r_oy;
    assign o_copy_valid    = r_ovalid;
    assign o_last_of_step  = r_olast;
    assign o_sequence_done = r_odone;
    assign o_aborted       = r_oab;

endmodule

`default_nettype wire
